// ===== design/spq_pkg.sv =====
// Shared types and constants of the stable priority queue.
`timescale 1ns / 1ps
package spq_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int PRIO_W       = 8;
	localparam int NAME_W       = 24;
	localparam int STATUS_W     = 2;
	localparam int OUT_COUNT_W  = 5;

	localparam logic [1:0] CMD_INSERT  = 2'd0;
	localparam logic [1:0] CMD_EXECUTE = 2'd1;
	localparam logic [1:0] CMD_COUNT   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic [1:0]        command;
		logic [PRIO_W-1:0] new_prio;
		logic [NAME_W-1:0] new_name;
	} cmd_t;

	typedef struct packed {
		logic [PRIO_W-1:0]      out_prio;
		logic [NAME_W-1:0]      out_name;
		logic [STATUS_W-1:0]    out_status;
		logic [OUT_COUNT_W-1:0] out_count;
		logic                   out_empty;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic run;
	} ctrl_t;

endpackage

// ===== design/spq_stream_if.sv =====
// Valid/ready channel interface carrying one payload beat.
`timescale 1ns / 1ps
interface spq_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== design/spq_ctrl.sv =====
// Controller state machine: sequences capture, update and result handoff.
`timescale 1ns / 1ps
module spq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output spq_pkg::ctrl_t ctl
);
	import spq_pkg::*;

	typedef enum logic {
		IDLE,
		RUN
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign accept      = cmd_valid && ready_q;
	assign out_free    = !out_valid_q || rsp_ready;
	assign ctl.capture = accept;
	assign ctl.run     = (state_q == RUN) && out_free;
	assign cmd_ready   = ready_q;
	assign rsp_valid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			ready_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (out_valid_q && rsp_ready) begin
						out_valid_q <= 1'b0;
					end
					if (accept) begin
						state_q <= RUN;
						ready_q <= 1'b0;
					end
				end
				RUN: begin
					// The result register must be free before the update commits.
					// A waiting beat that leaves in this cycle is replaced at once.
					if (out_free) begin
						state_q     <= IDLE;
						ready_q     <= 1'b1;
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

// ===== design/spq_dp.sv =====
// Datapath: command register, sorted row of entry cells, count and result register.
`timescale 1ns / 1ps
module spq_dp #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  spq_pkg::ctrl_t ctl,
	input  spq_pkg::cmd_t  cmd_in,
	output spq_pkg::rsp_t  rsp_out
);
	import spq_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	cmd_t              item_q;
	rsp_t              rsp_q;
	logic [PRIO_W-1:0] prio_q [CAPACITY];
	logic [NAME_W-1:0] name_q [CAPACITY];
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     count_nxt;
	logic [CAPACITY-1:0] gt;
	logic              full;
	logic              empty;
	logic              do_ins;
	logic              do_exe;
	logic [STATUS_W-1:0] status;

	assign full   = (count_q == CW'(CAPACITY));
	assign empty  = (count_q == '0);
	assign do_ins = ctl.run && (item_q.command == CMD_INSERT) && !full;
	assign do_exe = ctl.run && (item_q.command == CMD_EXECUTE) && !empty;

	// Each stored cell flags whether it ranks strictly behind the new entry;
	// the row stays sorted, so the flags form one run up to the count.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			gt[i] = (CW'(i) < count_q) && (prio_q[i] > item_q.new_prio);
		end
	end

	always_comb begin
		count_nxt = count_q;
		status    = ST_OK;
		case (item_q.command)
			CMD_INSERT: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					count_nxt = count_q + CW'(1);
				end
			end
			CMD_EXECUTE: begin
				if (empty) begin
					status = ST_UNDERFLOW;
				end else begin
					count_nxt = count_q - CW'(1);
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic ins_here;
		assign ins_here = gt[g] || (CW'(g) == count_q);

		if (g == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (do_ins && ins_here) begin
					prio_q[g] <= item_q.new_prio;
					name_q[g] <= item_q.new_name;
				end else if (do_exe) begin
					prio_q[g] <= prio_q[g+1];
					name_q[g] <= name_q[g+1];
				end
			end
		end else if (g == CAPACITY - 1) begin : g_tail
			always_ff @(posedge clk) begin
				if (do_ins && ins_here) begin
					prio_q[g] <= gt[g-1] ? prio_q[g-1] : item_q.new_prio;
					name_q[g] <= gt[g-1] ? name_q[g-1] : item_q.new_name;
				end
			end
		end else begin : g_mid
			always_ff @(posedge clk) begin
				if (do_ins && ins_here) begin
					prio_q[g] <= gt[g-1] ? prio_q[g-1] : item_q.new_prio;
					name_q[g] <= gt[g-1] ? name_q[g-1] : item_q.new_name;
				end else if (do_exe) begin
					prio_q[g] <= prio_q[g+1];
					name_q[g] <= name_q[g+1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.run) begin
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			item_q <= cmd_in;
		end
		if (ctl.run) begin
			rsp_q.out_prio   <= do_exe ? prio_q[0] : '0;
			rsp_q.out_name   <= do_exe ? name_q[0] : '0;
			rsp_q.out_status <= status;
			rsp_q.out_count  <= OUT_COUNT_W'(count_nxt);
			rsp_q.out_empty  <= (count_nxt == '0);
		end
	end

	assign rsp_out = rsp_q;

endmodule

// ===== design/stable_priority_queue.sv =====
// Top level of the stable priority queue: controller and datapath.
`timescale 1ns / 1ps
// Bounded priority queue of CAPACITY entries kept in service order in a row
// of registers. An insert goes behind every entry of equal or smaller
// priority, an execute removes the head, and a count query reports the fill
// level; every command beat yields exactly one response beat. A command is
// first captured into the command register; in the update step that follows,
// the whole row shifts or opens a gap in parallel and the response register
// loads. The next command is accepted in the cycle after the response is
// loaded, even while that response still waits; a stalled response holds
// the update step. Entries are not cleared at reset; only the count is.
module stable_priority_queue #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
	input logic          clk,
	input logic          arst_n,
	spq_stream_if.sink   cmd,
	spq_stream_if.source rsp
);
	import spq_pkg::*;

	ctrl_t ctl;
	rsp_t  rsp_data;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.ctl       (ctl)
	);

	spq_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.cmd_in  (cmd.payload),
		.rsp_out (rsp_data)
	);

	assign rsp.payload = rsp_data;

endmodule
